>>> hw/rtl/hsi_pkg.sv
// Shared types, mode codes and register indexes of the heater safety interlock.
package hsi_pkg;

  // Thermocouple channels and the fault mask bits that count
  localparam int unsigned SensorCount = 3;
  localparam int unsigned MaskWidth   = 3;
  localparam logic [MaskWidth-1:0] FaultMask =
    (SensorCount >= MaskWidth) ? {MaskWidth{1'b1}} : MaskWidth'((1 << SensorCount) - 1);

  // Rate test scale: milliseconds per second
  localparam int unsigned RateScale = 1000;

  // Mode codes, as reported on the state code output
  localparam logic [2:0] ModeStartup  = 3'd0;
  localparam logic [2:0] ModeOk       = 3'd1;
  localparam logic [2:0] ModeAirflow  = 3'd2;
  localparam logic [2:0] ModeOvertemp = 3'd3;
  localparam logic [2:0] ModeSensor   = 3'd4;
  localparam logic [2:0] ModeRate     = 3'd5;

  // Request types
  localparam logic ReqCheck = 1'b0;
  localparam logic ReqReset = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] RegStartupReads = 3'd0;
  localparam logic [2:0] RegProcessLimit = 3'd1;
  localparam logic [2:0] RegExhaustLimit = 3'd2;
  localparam logic [2:0] RegStaleLimit   = 3'd3;
  localparam logic [2:0] RegRateLimit    = 3'd4;
  localparam logic [2:0] RegResetLimit   = 3'd5;

  typedef struct packed {
    logic                  req_type;
    logic [MaskWidth-1:0]  tc_fault_mask;
    logic [MaskWidth-1:0]  tc_invalid_mask;
    logic signed [15:0]    process_temp;
    logic signed [15:0]    chamber_temp;
    logic signed [15:0]    exhaust_temp;
    logic                  blower_running;
    logic                  heater_active;
    logic [15:0]           sensor_age_ms;
    logic [31:0]           now_ms;
  } item_t;

  typedef struct packed {
    logic [7:0]         startup_reads_needed;
    logic signed [15:0] process_temp_limit;
    logic signed [15:0] exhaust_temp_limit;
    logic [15:0]        stale_limit_ms;
    logic [15:0]        rate_limit;
    logic signed [15:0] reset_temp_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [7:0]         good_read_count;
    logic signed [15:0] last_process_temp;
    logic [31:0]        last_sample_time;
    logic               last_sample_valid;
  } state_t;

  typedef struct packed {
    logic [2:0] state_code;
    logic       heater_off_cmd;
    logic       heater_release_cmd;
    logic       reset_accepted;
  } result_t;

endpackage

>>> hw/rtl/hsi_eval.sv
// Decision logic: next state and result for one request against the current state.
module hsi_eval (
  input  hsi_pkg::item_t   item_i,
  input  hsi_pkg::cfg_t    cfg_i,
  input  hsi_pkg::state_t  state_i,
  output hsi_pkg::state_t  state_o,
  output hsi_pkg::result_t result_o
);

  logic               any_fault;
  logic               reset_ok;
  logic [7:0]         count_inc;
  logic [31:0]        dt;
  logic signed [16:0] diff;
  logic [16:0]        diff_abs;
  logic [15:0]        ad;
  logic [26:0]        ad_scaled;
  logic [47:0]        rate_dt;
  logic               rate_bad;
  logic [2:0]         fault;

  assign any_fault = |(item_i.tc_fault_mask & hsi_pkg::FaultMask);

  assign reset_ok = !any_fault && (item_i.tc_invalid_mask == '0) &&
                    (item_i.process_temp <= cfg_i.reset_temp_limit) &&
                    (item_i.chamber_temp <= cfg_i.reset_temp_limit) &&
                    (item_i.exhaust_temp <= cfg_i.reset_temp_limit);

  assign count_inc = (state_i.good_read_count == 8'hFF) ? state_i.good_read_count
                                                        : state_i.good_read_count + 8'd1;

  // Rate of change as a multiply-compare: |dT| * 1000 > limit * dt
  assign dt        = item_i.now_ms - state_i.last_sample_time;
  assign diff      = 17'(item_i.process_temp) - 17'(state_i.last_process_temp);
  assign diff_abs  = diff[16] ? 17'(-diff) : 17'(diff);
  assign ad        = diff_abs[15:0];
  assign ad_scaled = 27'(ad) * 27'(hsi_pkg::RateScale);
  assign rate_dt   = 48'(cfg_i.rate_limit) * 48'(dt);
  assign rate_bad  = state_i.last_sample_valid && (dt != '0) &&
                     (48'(ad_scaled) > rate_dt);

  // Checks in priority order while in OK
  always_comb begin
    if (!item_i.blower_running && item_i.heater_active) begin
      fault = hsi_pkg::ModeAirflow;
    end else if (item_i.tc_invalid_mask[0] ||
                 (item_i.process_temp > cfg_i.process_temp_limit)) begin
      fault = hsi_pkg::ModeOvertemp;
    end else if (item_i.tc_invalid_mask[2] ||
                 (item_i.exhaust_temp > cfg_i.exhaust_temp_limit)) begin
      fault = hsi_pkg::ModeOvertemp;
    end else if (item_i.sensor_age_ms > cfg_i.stale_limit_ms) begin
      fault = hsi_pkg::ModeSensor;
    end else if (rate_bad) begin
      fault = hsi_pkg::ModeRate;
    end else if (any_fault) begin
      fault = hsi_pkg::ModeSensor;
    end else begin
      fault = hsi_pkg::ModeOk;
    end
  end

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (item_i.req_type == hsi_pkg::ReqReset) begin
      if (reset_ok) begin
        state_o.mode              = hsi_pkg::ModeOk;
        state_o.last_sample_valid = 1'b0;
        state_o.last_sample_time  = '0;
        result_o.heater_release_cmd = 1'b1;
        result_o.reset_accepted     = 1'b1;
      end
    end else if (state_i.mode == hsi_pkg::ModeStartup) begin
      result_o.heater_off_cmd = 1'b1;
      if (!any_fault) begin
        state_o.good_read_count = count_inc;
        if (count_inc >= cfg_i.startup_reads_needed) begin
          state_o.mode                = hsi_pkg::ModeOk;
          result_o.heater_release_cmd = 1'b1;
        end
      end else begin
        state_o.good_read_count = '0;
      end
    end else if (state_i.mode != hsi_pkg::ModeOk) begin
      result_o.heater_off_cmd = 1'b1;
    end else begin
      // Take the sample once the rate test has passed, even on a thermocouple fault
      if (fault == hsi_pkg::ModeOk ||
          (fault == hsi_pkg::ModeSensor && item_i.sensor_age_ms <= cfg_i.stale_limit_ms &&
           !rate_bad && !(item_i.tc_invalid_mask[0] ||
                          item_i.process_temp > cfg_i.process_temp_limit) &&
           !(item_i.tc_invalid_mask[2] ||
             item_i.exhaust_temp > cfg_i.exhaust_temp_limit) &&
           !(!item_i.blower_running && item_i.heater_active))) begin
        state_o.last_process_temp = item_i.process_temp;
        state_o.last_sample_time  = item_i.now_ms;
        state_o.last_sample_valid = 1'b1;
      end
      if (fault != hsi_pkg::ModeOk) begin
        state_o.mode            = fault;
        result_o.heater_off_cmd = 1'b1;
      end
    end
    result_o.state_code = state_o.mode;
  end

endmodule

>>> hw/rtl/heater_safety_interlock.sv
// Top level of the latching heater safety interlock: request register, state and result register.
// Each request is taken into the input register; its result is registered and shown from the
//   result register. Throughput: one request per cycle while the result is not stalled; the
//   input register, the decision logic and the result register form a single pass, and the next
//   request sees the state left by the previous one. A stalled result holds the result register;
//   the input register then holds too. Reset: asynchronous, active low; mode returns to startup,
//   counters and last sample clear, and the configuration registers return to their defaults.
module heater_safety_interlock (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [2:0]                      cfg_idx_i,
  input  logic [15:0]                     cfg_wdata_i,
  // Request channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            req_type_i,
  input  logic [hsi_pkg::MaskWidth-1:0]   tc_fault_mask_i,
  input  logic [hsi_pkg::MaskWidth-1:0]   tc_invalid_mask_i,
  input  logic signed [15:0]              process_temp_i,
  input  logic signed [15:0]              chamber_temp_i,
  input  logic signed [15:0]              exhaust_temp_i,
  input  logic                            blower_running_i,
  input  logic                            heater_active_i,
  input  logic [15:0]                     sensor_age_ms_i,
  input  logic [31:0]                     now_ms_i,
  // Result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [2:0]                      state_code_o,
  output logic                            heater_off_cmd_o,
  output logic                            heater_release_cmd_o,
  output logic                            reset_accepted_o
);

  hsi_pkg::cfg_t    cfg_q;
  hsi_pkg::state_t  state_q, state_d;
  hsi_pkg::item_t   item_q;
  hsi_pkg::result_t res_q, res_d;
  logic             in_valid_q;
  logic             out_valid_q;
  logic             advance;
  logic             in_take;

  // Configuration registers; the user writes only while the block is idle; no check enforces it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.startup_reads_needed <= 8'd3;
      cfg_q.process_temp_limit   <= 16'sd4160;
      cfg_q.exhaust_temp_limit   <= 16'sd4800;
      cfg_q.stale_limit_ms       <= 16'd2000;
      cfg_q.rate_limit           <= 16'd320;
      cfg_q.reset_temp_limit     <= 16'sd800;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hsi_pkg::RegStartupReads: cfg_q.startup_reads_needed <= cfg_wdata_i[7:0];
        hsi_pkg::RegProcessLimit: cfg_q.process_temp_limit   <= cfg_wdata_i;
        hsi_pkg::RegExhaustLimit: cfg_q.exhaust_temp_limit   <= cfg_wdata_i;
        hsi_pkg::RegStaleLimit:   cfg_q.stale_limit_ms       <= cfg_wdata_i;
        hsi_pkg::RegRateLimit:    cfg_q.rate_limit           <= cfg_wdata_i;
        hsi_pkg::RegResetLimit:   cfg_q.reset_temp_limit     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Advance the held request into the result register whenever that register is free
  // or being drained this cycle
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Request payload; no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.req_type        <= req_type_i;
      item_q.tc_fault_mask   <= tc_fault_mask_i;
      item_q.tc_invalid_mask <= tc_invalid_mask_i;
      item_q.process_temp    <= process_temp_i;
      item_q.chamber_temp    <= chamber_temp_i;
      item_q.exhaust_temp    <= exhaust_temp_i;
      item_q.blower_running  <= blower_running_i;
      item_q.heater_active   <= heater_active_i;
      item_q.sensor_age_ms   <= sensor_age_ms_i;
      item_q.now_ms          <= now_ms_i;
    end
  end

  hsi_eval u_eval (
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Latching state; update only when a request moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{mode: hsi_pkg::ModeStartup, good_read_count: 8'd0,
                   last_process_temp: 16'sd0, last_sample_time: 32'd0,
                   last_sample_valid: 1'b0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register: hold while stalled, drop when drained with nothing behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign state_code_o         = res_q.state_code;
  assign heater_off_cmd_o     = res_q.heater_off_cmd;
  assign heater_release_cmd_o = res_q.heater_release_cmd;
  assign reset_accepted_o     = res_q.reset_accepted;

  // A granted reset always releases the heater and lands in OK
  a_reset_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reset_accepted_o |->
      heater_release_cmd_o && !heater_off_cmd_o && state_code_o == hsi_pkg::ModeOk)
    else $error("granted reset did not release into OK");

  // A release is only ever reported together with the OK mode
  a_release_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && heater_release_cmd_o |-> state_code_o == hsi_pkg::ModeOk)
    else $error("release outside OK mode");

  // A check in a latched fault mode leaves the mode untouched
  a_fault_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && item_q.req_type == hsi_pkg::ReqCheck &&
    state_q.mode != hsi_pkg::ModeOk && state_q.mode != hsi_pkg::ModeStartup |=>
      $stable(state_q.mode))
    else $error("fault mode left on a check");

  // A request that moves on always produces a result next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result lost after advance");

endmodule

>>> test/tb.sv
// Self-checking testbench for the heater safety interlock: random and directed requests.
`timescale 1ns / 1ps

module tb;

  // Give up well past the slowest legal run.
  localparam int unsigned CycleLimit  = 400_000;
  localparam int unsigned MsPerSecond = 1000;
  localparam int unsigned ReqBits     = $bits(hsi_pkg::item_t);
  localparam int unsigned CfgBits     = $bits(hsi_pkg::cfg_t);
  // Thermocouple channels whose invalid flag trips a check
  localparam int unsigned ProcessTc   = 0;
  localparam int unsigned ExhaustTc   = 2;
  // Register indexes past the end of the map; writes there are dropped
  localparam logic [2:0]  NoRegLow    = hsi_pkg::RegResetLimit + 3'd1;
  localparam logic [2:0]  NoRegHigh   = hsi_pkg::RegResetLimit + 3'd2;

  typedef struct {
    hsi_pkg::item_t req;
    int unsigned    gap;
  } pending_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_idx_i   = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  state_code_o;
  logic        heater_off_cmd_o;
  logic        heater_release_cmd_o;
  logic        reset_accepted_o;

  // Request payload on the bus; every field is taken from one register
  hsi_pkg::item_t cur_req = '0;
  wire                          req_type_i        = cur_req.req_type;
  wire [hsi_pkg::MaskWidth-1:0] tc_fault_mask_i   = cur_req.tc_fault_mask;
  wire [hsi_pkg::MaskWidth-1:0] tc_invalid_mask_i = cur_req.tc_invalid_mask;
  wire signed [15:0]            process_temp_i    = cur_req.process_temp;
  wire signed [15:0]            chamber_temp_i    = cur_req.chamber_temp;
  wire signed [15:0]            exhaust_temp_i    = cur_req.exhaust_temp;
  wire                          blower_running_i  = cur_req.blower_running;
  wire                          heater_active_i   = cur_req.heater_active;
  wire [15:0]                   sensor_age_ms_i   = cur_req.sensor_age_ms;
  wire [31:0]                   now_ms_i          = cur_req.now_ms;

  // Predictor copy of the registers and of the interlock state
  hsi_pkg::cfg_t   limits;
  hsi_pkg::state_t interlock;

  pending_t         request_q[$];
  hsi_pkg::result_t outcome_q[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle     = 0;
  int unsigned rx_wait     = 0;
  bit          tx_calm     = 1'b0;
  bit          rx_calm     = 1'b0;
  logic        req_fire    = 1'b0;
  logic        res_fire    = 1'b0;
  logic [31:0] gen_now     = '0;
  int          gen_temp    = 0;

  heater_safety_interlock dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Work out the result of one accepted request and advance the predicted state.
  function automatic hsi_pkg::result_t interlock_step(hsi_pkg::item_t it);
    hsi_pkg::result_t res;
    logic        tc_fault;
    logic [2:0]  verdict;
    logic [31:0] elapsed;
    int          drift;
    logic [63:0] swing;
    logic [63:0] allowed;
    res = '0;
    tc_fault = |(it.tc_fault_mask & hsi_pkg::FaultMask);
    if (it.req_type == hsi_pkg::ReqReset) begin
      // Grant only with clean, valid sensors all at or under the reset ceiling
      if (!tc_fault && it.tc_invalid_mask == '0 &&
          $signed(it.process_temp) <= $signed(limits.reset_temp_limit) &&
          $signed(it.chamber_temp) <= $signed(limits.reset_temp_limit) &&
          $signed(it.exhaust_temp) <= $signed(limits.reset_temp_limit)) begin
        interlock.mode = hsi_pkg::ModeOk;
        interlock.last_sample_valid = 1'b0;
        interlock.last_sample_time = '0;
        res.heater_release_cmd = 1'b1;
        res.reset_accepted = 1'b1;
      end
    end else if (interlock.mode == hsi_pkg::ModeStartup) begin
      res.heater_off_cmd = 1'b1;
      if (tc_fault) begin
        interlock.good_read_count = '0;
      end else begin
        if (interlock.good_read_count != 8'hFF) begin
          interlock.good_read_count++;
        end
        if (interlock.good_read_count >= limits.startup_reads_needed) begin
          interlock.mode = hsi_pkg::ModeOk;
          res.heater_release_cmd = 1'b1;
        end
      end
    end else if (interlock.mode != hsi_pkg::ModeOk) begin
      res.heater_off_cmd = 1'b1;
    end else begin
      verdict = hsi_pkg::ModeOk;
      if (!it.blower_running && it.heater_active) begin
        verdict = hsi_pkg::ModeAirflow;
      end else if (it.tc_invalid_mask[ProcessTc] ||
                   $signed(it.process_temp) > $signed(limits.process_temp_limit)) begin
        verdict = hsi_pkg::ModeOvertemp;
      end else if (it.tc_invalid_mask[ExhaustTc] ||
                   $signed(it.exhaust_temp) > $signed(limits.exhaust_temp_limit)) begin
        verdict = hsi_pkg::ModeOvertemp;
      end else if (it.sensor_age_ms > limits.stale_limit_ms) begin
        verdict = hsi_pkg::ModeSensor;
      end else begin
        elapsed = it.now_ms - interlock.last_sample_time;
        if (interlock.last_sample_valid && elapsed != '0) begin
          drift = int'($signed(it.process_temp)) - int'($signed(interlock.last_process_temp));
          if (drift < 0) begin
            drift = -drift;
          end
          swing = 64'(drift) * 64'(MsPerSecond);
          allowed = 64'(limits.rate_limit) * 64'(elapsed);
          if (swing > allowed) begin
            verdict = hsi_pkg::ModeRate;
          end
        end
        if (verdict == hsi_pkg::ModeOk) begin
          interlock.last_process_temp = it.process_temp;
          interlock.last_sample_time = it.now_ms;
          interlock.last_sample_valid = 1'b1;
          if (tc_fault) begin
            verdict = hsi_pkg::ModeSensor;
          end
        end
      end
      if (verdict != hsi_pkg::ModeOk) begin
        interlock.mode = verdict;
        res.heater_off_cmd = 1'b1;
      end
    end
    res.state_code = interlock.mode;
    return res;
  endfunction

  task automatic compare_field(string label, logic [2:0] want, logic [2:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
      mismatches++;
    end
  endtask

  // Sample both handshakes on the rising edge; predict on request, check on result.
  always @(posedge clk_i) begin
    hsi_pkg::result_t want;
    req_fire <= in_valid_i && !in_stall_o;
    res_fire <= out_valid_o && !out_stall_i;
    if (out_valid_o && !out_stall_i) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result, got state %0d off %0b release %0b accepted %0b",
                 $time, state_code_o, heater_off_cmd_o, heater_release_cmd_o,
                 reset_accepted_o);
        mismatches++;
      end else begin
        want = outcome_q.pop_front();
        compare_field("state_code", want.state_code, state_code_o);
        compare_field("heater_off_cmd", 3'(want.heater_off_cmd), 3'(heater_off_cmd_o));
        compare_field("heater_release_cmd", 3'(want.heater_release_cmd),
                      3'(heater_release_cmd_o));
        compare_field("reset_accepted", 3'(want.reset_accepted), 3'(reset_accepted_o));
      end
    end
    if (in_valid_i && !in_stall_o) begin
      outcome_q.push_back(interlock_step(cur_req));
    end
  end

  // Request driver: hold a stalled request, idle for the drawn gap, then present the next.
  always @(negedge clk_i) begin
    pending_t ent;
    if (rst_ni && (!in_valid_i || req_fire)) begin
      if (tx_idle > 0) begin
        in_valid_i <= 1'b0;
        tx_idle--;
      end else if (request_q.size() > 0) begin
        ent = request_q.pop_front();
        cur_req <= ent.req;
        in_valid_i <= 1'b1;
        tx_idle = ent.gap;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result sink: after each result taken, draw a fresh stall; switch to calm spells now and then.
  always @(negedge clk_i) begin
    if (res_fire) begin
      if ($urandom_range(0, 31) == 0) begin
        rx_calm = !rx_calm;
      end
      rx_wait = rx_calm ? 0 : $urandom_range(0, 18);
    end
    if (rx_wait > 0) begin
      out_stall_i <= 1'b1;
      rx_wait--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Write one register and mirror it into the predictor's copy.
  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = value;
    case (idx)
      hsi_pkg::RegStartupReads: limits.startup_reads_needed = value[7:0];
      hsi_pkg::RegProcessLimit: limits.process_temp_limit = value;
      hsi_pkg::RegExhaustLimit: limits.exhaust_temp_limit = value;
      hsi_pkg::RegStaleLimit:   limits.stale_limit_ms = value;
      hsi_pkg::RegRateLimit:    limits.rate_limit = value;
      hsi_pkg::RegResetLimit:   limits.reset_temp_limit = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic apply_limits(hsi_pkg::cfg_t s);
    write_reg(hsi_pkg::RegStartupReads, {8'($urandom), s.startup_reads_needed});
    write_reg(hsi_pkg::RegProcessLimit, s.process_temp_limit);
    write_reg(hsi_pkg::RegExhaustLimit, s.exhaust_temp_limit);
    write_reg(hsi_pkg::RegStaleLimit, s.stale_limit_ms);
    write_reg(hsi_pkg::RegRateLimit, s.rate_limit);
    write_reg(hsi_pkg::RegResetLimit, s.reset_temp_limit);
    write_reg(NoRegLow, 16'($urandom));
    write_reg(NoRegHigh, 16'($urandom));
  endtask

  // Hold until every request is out and every result is back, then let the pipe drain.
  // Look at the rising edge, where the driver's outputs have settled.
  task automatic settle();
    while (request_q.size() != 0 || in_valid_i || outcome_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  function automatic void queue_req(hsi_pkg::item_t it);
    if ($urandom_range(0, 39) == 0) begin
      tx_calm = !tx_calm;
    end
    request_q.push_back('{req: it, gap: tx_calm ? 0 : $urandom_range(0, 18)});
  endfunction

  // Check request with clean sensors, blower and heater on, and the given temperature and time.
  function automatic hsi_pkg::item_t calm_item(logic [31:0] stamp, logic signed [15:0] temp);
    hsi_pkg::item_t it;
    it = '0;
    it.req_type = hsi_pkg::ReqCheck;
    it.process_temp = temp;
    it.blower_running = 1'b1;
    it.heater_active = 1'b1;
    it.now_ms = stamp;
    return it;
  endfunction

  function automatic hsi_pkg::item_t reset_item(logic signed [15:0] process,
                                                logic signed [15:0] chamber,
                                                logic signed [15:0] exhaust);
    hsi_pkg::item_t it;
    it = '0;
    it.req_type = hsi_pkg::ReqReset;
    it.process_temp = process;
    it.chamber_temp = chamber;
    it.exhaust_temp = exhaust;
    it.blower_running = 1'b1;
    return it;
  endfunction

  // Temperature at or under a ceiling, half the time within a few counts of it.
  function automatic logic signed [15:0] draw_at_most(logic signed [15:0] ceiling);
    int          top;
    int unsigned span;
    top = int'($signed(ceiling));
    span = 32'(top + 32768);
    if ($urandom_range(0, 1) == 1) begin
      return 16'(top - int'($urandom_range(0, (span < 32) ? span : 32)));
    end
    return 16'(top - int'($urandom_range(0, span)));
  endfunction

  // Mostly well-formed traffic: rate-bounded checks and clean reset requests, with
  // injected faults, refused resets and raw noise mixed in.
  function automatic hsi_pkg::item_t draw_request();
    hsi_pkg::item_t it;
    int unsigned roll;
    int unsigned step;
    longint      room;
    int          walk;
    it = '0;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      it = ReqBits'({$urandom, $urandom, $urandom, $urandom});
    end else if (roll < 20) begin
      it.req_type = hsi_pkg::ReqReset;
      it.process_temp = draw_at_most(limits.reset_temp_limit);
      it.chamber_temp = draw_at_most(limits.reset_temp_limit);
      it.exhaust_temp = draw_at_most(limits.reset_temp_limit);
      it.blower_running = 1'($urandom);
      it.heater_active = 1'($urandom);
      it.sensor_age_ms = 16'($urandom);
      it.now_ms = gen_now;
      if ($urandom_range(0, 3) == 0) begin
        it.tc_fault_mask = 3'($urandom);
        it.tc_invalid_mask = 3'($urandom);
        it.chamber_temp = 16'($urandom);
      end
      gen_temp = int'($signed(it.process_temp));
    end else begin
      step = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3000);
      if ($urandom_range(0, 49) == 0) begin
        step = $urandom;
      end
      gen_now += step;
      room = longint'(limits.rate_limit) * longint'(step) / MsPerSecond;
      if (room > 3000) begin
        room = 3000;
      end
      if ($urandom_range(0, 9) == 0) begin
        walk = int'($signed(16'($urandom)));
      end else begin
        walk = gen_temp + int'($urandom_range(0, 32'(2 * room))) - int'(room);
      end
      if (walk > int'($signed(limits.process_temp_limit))) begin
        walk = int'($signed(limits.process_temp_limit));
      end
      if (walk < -32768) begin
        walk = -32768;
      end
      gen_temp = walk;
      it.req_type = hsi_pkg::ReqCheck;
      it.process_temp = 16'(walk);
      it.chamber_temp = 16'($urandom);
      it.exhaust_temp = draw_at_most(limits.exhaust_temp_limit);
      it.blower_running = 1'b1;
      it.heater_active = 1'($urandom);
      it.sensor_age_ms = 16'($urandom_range(0, limits.stale_limit_ms));
      it.now_ms = gen_now;
      // a bad chamber reading alone never trips a check
      it.tc_invalid_mask[1] = 1'($urandom);
      if ($urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 5))
          0: begin
            it.blower_running = 1'b0;
            it.heater_active = 1'b1;
          end
          1: it.tc_invalid_mask = 3'($urandom_range(1, 7));
          2: it.tc_fault_mask = 3'($urandom_range(1, 7));
          3: it.sensor_age_ms = 16'($urandom_range(limits.stale_limit_ms, 16'hFFFF));
          4: it.process_temp = 16'($urandom);
          default: it.exhaust_temp = 16'($urandom);
        endcase
      end
    end
    return it;
  endfunction

  // Main sequence: reset, directed requests, then phases of random traffic under
  // different limits, each phase entered only once the block has gone quiet.
  initial begin
    hsi_pkg::item_t probe;
    hsi_pkg::cfg_t  setting;
    int unsigned    quota;
    limits = '{8'd3, 16'sd4160, 16'sd4800, 16'd2000, 16'd320, 16'sd800};
    interlock = '0;
    interlock.mode = hsi_pkg::ModeStartup;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    write_reg(hsi_pkg::RegStartupReads, 16'd4);

    // Startup: a faulted read clears the count, bad airflow and invalid readings are ignored
    probe = calm_item(32'd0, 16'sd0);
    probe.tc_fault_mask = 3'b100;
    queue_req(probe);
    probe = calm_item(32'd10, 16'sd0);
    probe.tc_invalid_mask = 3'b111;
    probe.blower_running = 1'b0;
    queue_req(probe);
    queue_req(calm_item(32'd20, 16'sd0));
    queue_req(calm_item(32'd30, 16'sd0));
    queue_req(calm_item(32'd40, 16'sd0));
    // First sample, then every limit met exactly with no time elapsed
    queue_req(calm_item(32'd1000, 16'sd100));
    probe = calm_item(32'd1000, 16'sd4160);
    probe.exhaust_temp = 16'sd4800;
    probe.sensor_age_ms = 16'd2000;
    queue_req(probe);
    // One count in one millisecond trips the rate test; the fault then latches
    queue_req(calm_item(32'd1001, 16'sd4159));
    queue_req(calm_item(32'd2000, 16'sd0));
    // Refused resets: one hot sensor, an invalid reading, a faulted thermocouple; then one granted at the ceiling
    queue_req(reset_item(16'sd0, 16'sd801, 16'sd0));
    probe = reset_item(16'sd0, 16'sd0, 16'sd0);
    probe.tc_invalid_mask = 3'b010;
    queue_req(probe);
    probe = reset_item(16'sd0, 16'sd0, 16'sd0);
    probe.tc_fault_mask = 3'b001;
    queue_req(probe);
    queue_req(reset_item(16'sd800, 16'sd800, 16'sh8000));
    // Airflow takes priority over a process over-temperature
    probe = calm_item(32'd3000, 16'sh7FFF);
    probe.blower_running = 1'b0;
    queue_req(probe);
    queue_req(reset_item(16'sh8000, 16'sh8000, 16'sh8000));
    probe = calm_item(32'd3100, 16'sd0);
    probe.tc_invalid_mask = 3'b001;
    queue_req(probe);
    queue_req(reset_item(16'sd0, 16'sd0, 16'sd0));
    probe = calm_item(32'd3200, 16'sd0);
    probe.exhaust_temp = 16'sd4801;
    probe.tc_invalid_mask = 3'b010;
    queue_req(probe);
    queue_req(reset_item(16'sd0, 16'sd0, 16'sd0));
    // Stale data wins over a thermocouple fault
    probe = calm_item(32'd3300, 16'sd0);
    probe.sensor_age_ms = 16'hFFFF;
    probe.tc_fault_mask = 3'b001;
    queue_req(probe);
    queue_req(reset_item(16'sd0, 16'sd0, 16'sd0));
    // Timestamp wrap: rate test passes near its edge, sample kept, then fault mask trips
    probe = calm_item(32'hFFFF_FFF0, 16'sd0);
    probe.blower_running = 1'b0;
    probe.heater_active = 1'b0;
    queue_req(probe);
    probe = calm_item(32'h0000_0010, 16'sd10);
    probe.tc_fault_mask = 3'b010;
    queue_req(probe);
    queue_req(reset_item(16'sd0, 16'sd0, 16'sd0));
    queue_req(calm_item(32'hFFFF_FFFF, 16'sh8000));

    gen_now = $urandom;
    repeat (140) queue_req(draw_request());

    for (int ph = 1; ph <= 6; ph++) begin
      settle();
      case (ph)
        1: setting = '{8'd255, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF, 16'sh7FFF};
        2: setting = '{8'd0, 16'sh8000, 16'sh8000, 16'd0, 16'd0, 16'sh8000};
        3: setting = '{8'd1, 16'sd3000, 16'sd3500, 16'd500, 16'd50, 16'sd400};
        4: begin
          setting.startup_reads_needed = 8'($urandom);
          setting.process_temp_limit = 16'($urandom_range(0, 16000));
          setting.exhaust_temp_limit = 16'($urandom_range(0, 16000));
          setting.stale_limit_ms = 16'($urandom_range(0, 5000));
          setting.rate_limit = 16'($urandom_range(0, 4000));
          setting.reset_temp_limit = 16'(int'($urandom_range(0, 4000)) - 2000);
        end
        default: setting = CfgBits'({$urandom, $urandom, $urandom});
      endcase
      apply_limits(setting);
      gen_now = $urandom;
      quota = (ph == 2) ? 60 : 100;
      repeat (quota) queue_req(draw_request());
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: count cycles and end the run if traffic never drains.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> heater_safety_interlock.f
hw/rtl/hsi_pkg.sv
hw/rtl/hsi_eval.sv
hw/rtl/heater_safety_interlock.sv
test/tb.sv
